// ----- rtl/fct_pkg.sv -----
// ----------------------------------------------------------------------------
// fct_pkg: shared definitions of the cluster table engine
// Types, mode and status codes, entry marks and default sizes.
// ----------------------------------------------------------------------------
package fct_pkg;

    // Default number of table entries held in the memory.
    localparam int CLUSTERS_DEF = 4096;

    // Fixed field widths.
    localparam int MODE_W    = 3;
    localparam int CLUSTER_W = 12;
    localparam int ENTRY_W   = 13;
    localparam int COUNT_W   = 13;
    localparam int STATUS_W  = 2;

    // Entry marks.
    localparam logic [ENTRY_W-1:0] MARK_END    = 13'd4096;
    localparam logic [ENTRY_W-1:0] MARK_UNUSED = 13'd4097;

    // Reset value of the size register.
    localparam logic [ENTRY_W-1:0] ACTIVE_RESET = 13'd4096;

    // Mode codes.
    localparam logic [MODE_W-1:0] MODE_INIT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd1;
    localparam logic [MODE_W-1:0] MODE_COUNT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FREE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CHAIN = 3'd4;
    localparam logic [MODE_W-1:0] MODE_WRITE = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LONG  = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_CH_RD,
        S_CH_WB,
        S_DONE
    } t_state;

endpackage

// ----- rtl/fct_ram.sv -----
// ----------------------------------------------------------------------------
// fct_ram: generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module fct_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/fat_cluster_table_engine_core.sv -----
// ----------------------------------------------------------------------------
// fat_cluster_table_engine_core: file allocation table engine
// Keeps a table of cluster entries in one RAM and runs init, allocate, count,
// free, chain clear and write items against it, one item at a time.
// ----------------------------------------------------------------------------
// The table lives in a single RAM with one write port and one registered read
// port, so every mode is a sequence of RAM accesses. After reset the block
// first sweeps the RAM and marks every entry unused, with o_in_stall high
// throughout the sweep (size writes are accepted as ever).
// Let N be the table size, the lesser of the size register and CLUSTERS.
// Init writes one entry per cycle. Allocate and count stream one read per
// cycle through the RAM port; count scans all N entries and allocate stops
// at the first unused entry; with an empty table both go straight to the
// result.
// Chain clear needs a read and a write-back for every entry it visits, save
// one found already unused, which is only read; a walk that stops on the
// length limit or on a link out of the table ends on that check.
// Free one, write entry and unknown modes go straight to the result. A
// finished result waits in an output register, and the block takes the next
// item while it waits; a second result that is ready before the first is
// taken waits in the result state, with o_in_stall high.
module fat_cluster_table_engine_core
    import fct_pkg::*;
#(
    parameter int CLUSTERS = CLUSTERS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Size register write port
    input  logic                 i_cfg_we,
    input  logic [ENTRY_W-1:0]   i_cfg_data,
    // Input item channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [CLUSTER_W-1:0] i_cluster,
    input  logic [ENTRY_W-1:0]   i_entry_value,
    // Result item channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CLUSTER_W-1:0] o_found_cluster,
    output logic [COUNT_W-1:0]   o_free_count,
    output logic [STATUS_W-1:0]  o_status
);

    localparam int AW = $clog2(CLUSTERS);
    // Working width for turning a 13-bit index into a RAM address.
    localparam int IW = (AW > ENTRY_W) ? AW : ENTRY_W;
    localparam logic [31:0] CLUSTERS_L = 32'(CLUSTERS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(CLUSTERS - 1);

    // Turns a 13-bit index into a RAM address. Indexes used for an access are
    // always below the table size, so dropping upper bits loses nothing.
    function automatic logic [AW-1:0] to_addr(input logic [ENTRY_W-1:0] v);
        logic [IW-1:0] w;
        w = IW'(v);
        return w[AW-1:0];
    endfunction

    t_state r_state, n_state;

    logic [ENTRY_W-1:0]   r_active;
    logic [AW-1:0]        r_clr, n_clr;
    logic [MODE_W-1:0]    r_mode, n_mode;
    logic [ENTRY_W-1:0]   r_size, n_size;
    logic [ENTRY_W-1:0]   r_idx, n_idx;
    logic [ENTRY_W-1:0]   r_pidx, n_pidx;
    logic                 r_pend, n_pend;
    logic [ENTRY_W-1:0]   r_steps, n_steps;
    logic [ENTRY_W-1:0]   r_found, n_found;
    logic [COUNT_W-1:0]   r_cnt, n_cnt;
    logic [STATUS_W-1:0]  r_stat, n_stat;

    logic                 r_out_valid;
    logic [CLUSTER_W-1:0] r_out_found;
    logic [COUNT_W-1:0]   r_out_cnt;
    logic [STATUS_W-1:0]  r_out_stat;

    // RAM port signals
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [ENTRY_W-1:0]   mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [ENTRY_W-1:0]   mem_rdata;

    // Shared decisions
    logic                 w_accept;
    logic [ENTRY_W-1:0]   w_size;
    logic                 w_cl_ok;
    logic                 w_val_ok;
    logic                 w_scan_hit;
    logic                 w_scan_issue;
    logic                 w_scan_end;
    logic                 w_ch_long;
    logic                 w_ch_range;
    logic                 w_rd_unused;
    logic                 w_rd_end;
    logic                 w_out_free;

    fct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CLUSTERS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // The effective size is the register value capped at the RAM depth.
    assign w_size = (32'(r_active) > CLUSTERS_L) ? CLUSTERS_L[ENTRY_W-1:0] : r_active;

    assign o_in_stall   = (r_state != S_IDLE);
    assign w_accept     = i_in_valid && (r_state == S_IDLE);
    assign w_cl_ok      = ({1'b0, i_cluster} < w_size);
    assign w_val_ok     = (i_entry_value <= MARK_UNUSED);

    assign w_rd_unused  = (mem_rdata == MARK_UNUSED);
    assign w_rd_end     = (mem_rdata == MARK_END);

    // Scan pipeline: a read is issued at r_idx, its data returns next cycle
    // tagged with r_pidx.
    assign w_scan_hit   = r_pend && w_rd_unused;
    assign w_scan_issue = (r_idx != r_size);
    assign w_scan_end   = !w_scan_issue && !r_pend;

    // The length limit is checked before the index, as in a walk that counts
    // its steps first.
    assign w_ch_long    = (r_steps == r_size);
    assign w_ch_range   = (r_idx >= r_size);

    assign w_out_free   = !r_out_valid || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_mode) inside
                        MODE_INIT:              n_state = S_INIT;
                        MODE_ALLOC, MODE_COUNT: n_state = S_SCAN;
                        MODE_CHAIN:             n_state = S_CH_RD;
                        default:                n_state = S_DONE;
                    endcase
                end
            end
            S_INIT: begin
                if (r_idx == r_size) begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if ((r_mode == MODE_ALLOC && w_scan_hit) || w_scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_CH_RD: begin
                if (w_ch_long || w_ch_range) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CH_WB;
                end
            end
            S_CH_WB: begin
                if (w_rd_unused || w_rd_end) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CH_RD;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: RAM accesses and datapath updates
    always_comb begin
        n_clr     = r_clr;
        n_mode    = r_mode;
        n_size    = r_size;
        n_idx     = r_idx;
        n_pidx    = r_pidx;
        n_pend    = 1'b0;
        n_steps   = r_steps;
        n_found   = r_found;
        n_cnt     = r_cnt;
        n_stat    = r_stat;
        mem_we    = 1'b0;
        mem_waddr = to_addr(r_idx);
        mem_wdata = MARK_UNUSED;
        mem_re    = 1'b0;
        mem_raddr = to_addr(r_idx);
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_mode  = i_mode;
                    n_size  = w_size;
                    n_idx   = (i_mode == MODE_CHAIN) ? {1'b0, i_cluster} : '0;
                    n_steps = '0;
                    n_found = '0;
                    n_cnt   = '0;
                    n_stat  = ST_OK;
                    mem_waddr = to_addr({1'b0, i_cluster});
                    case (i_mode)
                        MODE_FREE: begin
                            if (w_cl_ok) begin
                                mem_we = 1'b1;
                            end else begin
                                n_stat = ST_RANGE;
                            end
                        end
                        MODE_WRITE: begin
                            mem_wdata = i_entry_value;
                            if (w_cl_ok && w_val_ok) begin
                                mem_we = 1'b1;
                            end else begin
                                n_stat = ST_RANGE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_INIT: begin
                if (r_idx != r_size) begin
                    mem_we = 1'b1;
                    n_idx  = r_idx + 1'b1;
                end
            end
            S_SCAN: begin
                if (w_scan_issue) begin
                    mem_re = 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_idx;
                    n_idx  = r_idx + 1'b1;
                end
                if (w_scan_hit) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (r_mode == MODE_ALLOC) begin
                    if (w_scan_hit) begin
                        n_found = r_pidx;
                        n_stat  = ST_OK;
                    end else if (w_scan_end) begin
                        n_stat = ST_FULL;
                    end
                end
            end
            S_CH_RD: begin
                if (w_ch_long) begin
                    n_stat = ST_LONG;
                end else if (w_ch_range) begin
                    n_stat = ST_RANGE;
                end else begin
                    mem_re = 1'b1;
                end
            end
            S_CH_WB: begin
                if (w_rd_unused) begin
                    n_stat = ST_RANGE;
                end else begin
                    mem_we  = 1'b1;
                    n_steps = r_steps + 1'b1;
                    n_idx   = mem_rdata;
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_active    <= ACTIVE_RESET;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pend  <= n_pend;
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_size  <= n_size;
        r_idx   <= n_idx;
        r_pidx  <= n_pidx;
        r_steps <= n_steps;
        r_found <= n_found;
        r_cnt   <= n_cnt;
        r_stat  <= n_stat;
        if (r_state == S_DONE && w_out_free) begin
            r_out_found <= (r_mode == MODE_ALLOC) ? r_found[CLUSTER_W-1:0] : '0;
            r_out_cnt   <= (r_mode == MODE_COUNT) ? r_cnt : '0;
            r_out_stat  <= r_stat;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found_cluster = r_out_found;
    assign o_free_count    = r_out_cnt;
    assign o_status        = r_out_stat;

endmodule
